@@ rtl/tspcm_pkg.sv @@
// Shared types, constants and helper functions for the transport stream PID
// continuity monitor. No dependencies; every other file in rtl/ uses this one.
package tspcm_pkg;

    // Table geometry and counter width.
    localparam int unsigned PID_BITS    = 13;
    localparam int unsigned PID_ENTRIES = 8192;
    localparam int unsigned IDX_BITS    = $clog2(PID_ENTRIES);
    localparam int unsigned COUNT_BITS  = 32;
    localparam int unsigned OUT_BITS    = 32;
    localparam int unsigned EXP_BITS    = 5;
    localparam int unsigned CC_BITS     = 4;

    // Table index is pid modulo PID_ENTRIES, done as a multiply by a
    // reciprocal followed by one compare-and-subtract correction.
    localparam int unsigned RECIP_SHIFT = 26;
    localparam int unsigned PROD_BITS   = PID_BITS + RECIP_SHIFT + 1;
    localparam logic [RECIP_SHIFT:0] RECIP =
        (RECIP_SHIFT + 1)'((64'd1 << RECIP_SHIFT) / PID_ENTRIES);

    localparam logic [7:0] SYNC_VALUE = 8'h47;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_BITS-1:0]   t_idx;

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] pid_high_byte;
        logic [7:0] pid_low_byte;
        logic [7:0] flags_byte;
    } t_in_word;

    typedef struct packed {
        logic                packet_ok;
        logic [PID_BITS-1:0] pid;
        logic [OUT_BITS-1:0] packet_total;
        logic [OUT_BITS-1:0] drop_total;
        logic [OUT_BITS-1:0] scrambled_total;
        logic [OUT_BITS-1:0] sync_error_total;
    } t_out_word;

    // One table entry holds all per-PID state.
    typedef struct packed {
        t_count              total;
        t_count              dropped;
        t_count              scrambled;
        logic [EXP_BITS-1:0] expected;
    } t_entry;

    typedef struct packed {
        logic en;
        t_idx idx;
    } t_ram_rd;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_entry entry;
    } t_ram_wr;

    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? v : v + t_count'(1);
    endfunction

endpackage

@@ rtl/ts_pid_continuity_monitor_core.sv @@
// Top level of the transport stream PID continuity monitor: index pipeline,
// sync error counter and output register. Depends on tspcm_pkg,
// tspcm_entry_ram and tspcm_update.
//
//  Channel | Direction | Handshake               | Word
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_word  (t_in_word)
//  out     | output    | o_out_valid/ i_out_stall| o_out_word (t_out_word)
//
// Each header word goes through stage 0, which forms the table index,
// stage 1, which waits for the registered read of the entry memory, and the
// output register. Up to one word is in each stage, so a new word can be taken
// every cycle when not stalled; the single read-modify-write port of the
// entry memory sets that figure, with a forwarding path covering back-to-back
// words of the same PID. After reset the entry memory is cleared one entry
// per cycle, PID_ENTRIES (8192) entries in all, during which o_in_stall
// stays high. Reset is synchronous and active low. Holding i_out_stall fills
// the stages behind the output register and then raises o_in_stall.
module ts_pid_continuity_monitor_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tspcm_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tspcm_pkg::t_out_word o_out_word
);

    // Stage 0 holds the accepted word and the reciprocal quotient estimate.
    logic                           r_s0_valid;
    tspcm_pkg::t_in_word            r_s0_word;
    logic [tspcm_pkg::PID_BITS-1:0] r_s0_quo;

    // Stage 1 waits for the entry read issued when it was loaded.
    logic                           r_s1_valid;
    tspcm_pkg::t_in_word            r_s1_word;
    tspcm_pkg::t_idx                r_s1_idx;

    logic                           r_out_valid;
    tspcm_pkg::t_out_word           r_out_word;
    tspcm_pkg::t_count              r_sync_cnt;

    logic                           w_out_free;
    logic                           w_s1_adv;
    logic                           w_s1_free;
    logic                           w_s0_adv;
    logic                           w_s0_free;
    logic                           w_in_acc;
    logic                           w_clr_busy;

    logic [tspcm_pkg::PID_BITS-1:0] w_in_pid;
    logic [tspcm_pkg::PROD_BITS-1:0] w_prod;
    logic [tspcm_pkg::PID_BITS-1:0] w_s0_pid;
    logic [tspcm_pkg::PID_BITS:0]   w_qn;
    logic [tspcm_pkg::PID_BITS-1:0] w_rem;
    logic [tspcm_pkg::PID_BITS:0]   w_rem_fix;
    tspcm_pkg::t_idx                w_idx;

    tspcm_pkg::t_ram_rd             w_rd;
    tspcm_pkg::t_ram_wr             w_wr;
    tspcm_pkg::t_entry              w_rd_entry;
    tspcm_pkg::t_entry              w_new_entry;
    logic                           w_good;
    tspcm_pkg::t_count              w_new_sync;
    tspcm_pkg::t_out_word           w_res_word;

    // Flow control: each stage moves when the one ahead is empty or moving.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign w_s1_free  = !r_s1_valid || w_s1_adv;
    assign w_s0_adv   = r_s0_valid && w_s1_free;
    assign w_s0_free  = !r_s0_valid || w_s0_adv;
    assign o_in_stall = w_clr_busy || !w_s0_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Quotient estimate floor(pid * RECIP / 2^RECIP_SHIFT) is either the true
    // quotient of pid by PID_ENTRIES or one less; it is registered here.
    assign w_in_pid = {i_in_word.pid_high_byte[4:0], i_in_word.pid_low_byte};
    assign w_prod   = tspcm_pkg::PROD_BITS'(w_in_pid)
                      * tspcm_pkg::PROD_BITS'(tspcm_pkg::RECIP);

    // In stage 0 the remainder gets its one correction step.
    assign w_s0_pid  = {r_s0_word.pid_high_byte[4:0], r_s0_word.pid_low_byte};
    assign w_qn      = (tspcm_pkg::PID_BITS + 1)'(r_s0_quo)
                       * (tspcm_pkg::PID_BITS + 1)'(tspcm_pkg::PID_ENTRIES);
    assign w_rem     = w_s0_pid - w_qn[tspcm_pkg::PID_BITS-1:0];

    always_comb begin
        w_rem_fix = {1'b0, w_rem};
        if (w_rem_fix >= (tspcm_pkg::PID_BITS + 1)'(tspcm_pkg::PID_ENTRIES)) begin
            w_rem_fix = w_rem_fix - (tspcm_pkg::PID_BITS + 1)'(tspcm_pkg::PID_ENTRIES);
        end
    end

    assign w_idx = w_rem_fix[tspcm_pkg::IDX_BITS-1:0];

    assign w_rd.en  = w_s0_adv;
    assign w_rd.idx = w_idx;

    assign w_wr.en    = w_s1_adv && w_good;
    assign w_wr.idx   = r_s1_idx;
    assign w_wr.entry = w_new_entry;

    tspcm_entry_ram u_entry_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (w_rd),
        .i_wr       (w_wr),
        .o_rd_entry (w_rd_entry),
        .o_clr_busy (w_clr_busy)
    );

    tspcm_update u_update (
        .i_word     (r_s1_word),
        .i_entry    (w_rd_entry),
        .i_sync_cnt (r_sync_cnt),
        .o_entry    (w_new_entry),
        .o_good     (w_good),
        .o_sync_cnt (w_new_sync),
        .o_out_word (w_res_word)
    );

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s0_word <= i_in_word;
            r_s0_quo  <= w_prod[tspcm_pkg::RECIP_SHIFT +: tspcm_pkg::PID_BITS];
        end
        if (w_s0_adv) begin
            r_s1_word <= r_s0_word;
            r_s1_idx  <= w_idx;
        end
        if (w_s1_adv) begin
            r_out_word <= w_res_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sync_cnt  <= '0;
        end else begin
            if (w_s0_free) begin
                r_s0_valid <= w_in_acc;
            end
            if (w_s1_free) begin
                r_s1_valid <= w_s0_adv;
            end
            if (w_out_free) begin
                r_out_valid <= w_s1_adv;
            end
            if (w_s1_adv) begin
                r_sync_cnt <= w_new_sync;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The clearing sweep owns the memory, so no item may reach the read or write port.
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_clr_busy && (w_wr.en || w_rd.en)))
        else $error("entry memory accessed during clearing sweep");

    // A result appears only after stage 1 held a word.
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result without a word in stage 1");

    // An accepted word is held in stage 0 on the next cycle.
    a_accept_loads_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s0_valid)
        else $error("accepted word lost before stage 0");

    // The sync error count only ever climbs.
    a_sync_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_sync_cnt >= $past(r_sync_cnt)))
        else $error("sync error count decreased");

endmodule

@@ rtl/tspcm_entry_ram.sv @@
// Per-PID entry memory with a registered read, a clearing sweep
// after reset and same-edge write forwarding. Depends on tspcm_pkg.
module tspcm_entry_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tspcm_pkg::t_ram_rd i_rd,
    input  tspcm_pkg::t_ram_wr i_wr,
    output tspcm_pkg::t_entry  o_rd_entry,
    output logic               o_clr_busy
);

    tspcm_pkg::t_entry mem [tspcm_pkg::PID_ENTRIES];

    tspcm_pkg::t_entry r_rd_data;
    tspcm_pkg::t_entry r_fwd_data;
    logic              r_fwd_hit;
    logic              r_clr_busy;
    tspcm_pkg::t_idx   r_clr_addr;

    logic              w_we;
    tspcm_pkg::t_idx   w_wa;
    tspcm_pkg::t_entry w_wd;

    // The sweep owns the write port until every entry has been zeroed.
    always_comb begin
        if (r_clr_busy) begin
            w_we = 1'b1;
            w_wa = r_clr_addr;
            w_wd = '0;
        end else begin
            w_we = i_wr.en;
            w_wa = i_wr.idx;
            w_wd = i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (i_rd.en) begin
            r_rd_data  <= mem[i_rd.idx];
            r_fwd_data <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + tspcm_pkg::t_idx'(1);
                if (r_clr_addr == tspcm_pkg::t_idx'(tspcm_pkg::PID_ENTRIES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // A read that lands on the edge of a write to the same entry sees
            // the old array contents, so the written value is kept aside.
            if (i_rd.en) begin
                r_fwd_hit <= i_wr.en && (i_wr.idx == i_rd.idx);
            end
        end
    end

    assign o_rd_entry = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

@@ rtl/tspcm_update.sv @@
// Combinational update of one PID entry and the sync error count, and
// assembly of the result word. Depends on tspcm_pkg.
module tspcm_update (
    input  tspcm_pkg::t_in_word  i_word,
    input  tspcm_pkg::t_entry    i_entry,
    input  tspcm_pkg::t_count    i_sync_cnt,
    output tspcm_pkg::t_entry    o_entry,
    output logic                 o_good,
    output tspcm_pkg::t_count    o_sync_cnt,
    output tspcm_pkg::t_out_word o_out_word
);

    localparam int unsigned PAYLOAD_BIT = 4;

    logic                                 w_good;
    logic                                 w_payload;
    logic                                 w_scrambled;
    logic [tspcm_pkg::CC_BITS-1:0]        w_cc;
    logic                                 w_mismatch;
    logic [tspcm_pkg::PID_BITS-1:0]       w_pid;
    tspcm_pkg::t_entry                    w_entry;
    tspcm_pkg::t_count                    w_sync_cnt;

    assign w_good      = (i_word.sync_byte == tspcm_pkg::SYNC_VALUE);
    assign w_payload   = i_word.flags_byte[PAYLOAD_BIT];
    assign w_scrambled = (i_word.flags_byte[7:6] != 2'b00);
    assign w_cc        = i_word.flags_byte[tspcm_pkg::CC_BITS-1:0];
    assign w_pid       = {i_word.pid_high_byte[4:0], i_word.pid_low_byte};

    // An expected value of zero marks a PID never seen with payload.
    assign w_mismatch = w_payload && (i_entry.expected != '0)
                        && (i_entry.expected[tspcm_pkg::CC_BITS-1:0] != w_cc);

    always_comb begin
        w_entry       = i_entry;
        w_entry.total = tspcm_pkg::sat_inc(i_entry.total);
        if (w_mismatch) begin
            w_entry.dropped = tspcm_pkg::sat_inc(i_entry.dropped);
        end
        if (w_payload) begin
            w_entry.expected = tspcm_pkg::EXP_BITS'(w_cc) + tspcm_pkg::EXP_BITS'(1);
        end
        if (w_scrambled) begin
            w_entry.scrambled = tspcm_pkg::sat_inc(i_entry.scrambled);
        end
    end

    assign w_sync_cnt = w_good ? i_sync_cnt : tspcm_pkg::sat_inc(i_sync_cnt);

    always_comb begin
        o_out_word                  = '0;
        o_out_word.packet_ok        = w_good;
        o_out_word.sync_error_total = tspcm_pkg::OUT_BITS'(w_sync_cnt);
        if (w_good) begin
            o_out_word.pid             = w_pid;
            o_out_word.packet_total    = tspcm_pkg::OUT_BITS'(w_entry.total);
            o_out_word.drop_total      = tspcm_pkg::OUT_BITS'(w_entry.dropped);
            o_out_word.scrambled_total = tspcm_pkg::OUT_BITS'(w_entry.scrambled);
        end
    end

    assign o_entry    = w_entry;
    assign o_good     = w_good;
    assign o_sync_cnt = w_sync_cnt;

endmodule
